@@ rtl/mdioc45_pkg.sv @@
package mdioc45_pkg;

  // depth of the queue between classifier and frame engine
  localparam int unsigned QueueDepth = 2;

  // preamble length after reset, in mdc periods
  localparam logic [7:0] PreambleReset = 8'd32;

  // command codes on the input channel
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ADDR     = 3'd1;
  localparam logic [2:0] CMD_WRITE    = 3'd2;
  localparam logic [2:0] CMD_READ     = 3'd3;
  localparam logic [2:0] CMD_READ_INC = 3'd4;

  // frame operations
  localparam logic [1:0] OP_ADDR     = 2'd0;
  localparam logic [1:0] OP_WRITE    = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_READ_INC = 2'd3;

  // fixed header bits: st and opcode, plus ta for the address and write headers
  localparam logic [15:0] HDR_ADDR     = 16'h0002;
  localparam logic [15:0] HDR_WRITE    = 16'h1002;
  localparam logic [13:0] HDR_READ     = 14'h0c00;
  localparam logic [13:0] HDR_READ_INC = 14'h0800;

  // classified item handed from the front to the back
  typedef struct packed {
    logic        is_start;
    logic [1:0]  op;
    logic [31:0] frame;
    logic        mdi;
  } item_t;

  // one result item
  typedef struct packed {
    logic        mdc_pulse;
    logic        mdio_out;
    logic        mdio_drive;
    logic        busy;
    logic        done;
    logic        rejected;
    logic [15:0] read_data;
  } res_t;

endpackage

@@ rtl/mdio_clause45_master.sv @@
// clause 45 mdio management master, one mdc period per tick item
//
// input channel (in_valid / in_stall): each item is a command. a start
// command (address, write, read, read increment) loads a frame when the
// master is idle and is rejected while a frame runs. a tick item stands
// for one mdc period; while a frame runs its result gives the pin levels
// for that period, and in_mdio_in is the line level at the period's end.
// result channel (out_valid / out_stall): exactly one result item per
// input item, in order. read_data is valid with done of a read.
// cfg_we / cfg_wdata write the preamble length (mdc periods of ones);
// write it only while no frame is running and the result side is empty.
// path: an accepted item is written to the queue, then taken into the frame
// engine's output register, and out_valid rises with that register.
// throughput: one item per clock while out_stall is low; the frame engine
// steps once per item, and a two-entry queue sits in between.
// when out_stall is held the result register holds, the queue fills, and
// in_stall rises once the queue is full; nothing is dropped.
// reset (synchronous, active low): idle, bus released, queue empty,
// preamble length 32.
module mdio_clause45_master #(
  parameter int unsigned QUEUE_DEPTH = mdioc45_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [4:0]  in_port_address,
  input  logic [4:0]  in_device_address,
  input  logic [15:0] in_data_word,
  input  logic        in_mdio_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_mdc_pulse,
  output logic        out_mdio_out,
  output logic        out_mdio_drive,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_start_rejected,
  output logic [15:0] out_read_data
);
  import mdioc45_pkg::*;

  logic [7:0] preamble_r;
  item_t      front_item;
  item_t      q_item;
  logic       q_valid;
  logic       q_ready;
  res_t       res;

  // preamble length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r <= PreambleReset;
    end else if (cfg_we) begin
      preamble_r <= cfg_wdata;
    end
  end

  // classify the command and build the frame bits
  mdioc45_front u_front (
    .command        (in_command),
    .port_address   (in_port_address),
    .device_address (in_device_address),
    .data_word      (in_data_word),
    .mdio_in        (in_mdio_in),
    .item           (front_item)
  );

  // decoupling queue, stalls the input side only when full
  mdioc45_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // frame engine with registered result
  mdioc45_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .preamble_length (preamble_r),
    .item_valid      (q_valid),
    .item_ready      (q_ready),
    .item            (q_item),
    .res_valid       (out_valid),
    .res_stall       (out_stall),
    .res             (res)
  );

  assign out_mdc_pulse      = res.mdc_pulse;
  assign out_mdio_out       = res.mdio_out;
  assign out_mdio_drive     = res.mdio_drive;
  assign out_busy_res       = res.busy;
  assign out_done_res       = res.done;
  assign out_start_rejected = res.rejected;
  assign out_read_data      = res.read_data;

endmodule

@@ rtl/mdioc45_front.sv @@
module mdioc45_front (
  input  logic [2:0]          command,
  input  logic [4:0]          port_address,
  input  logic [4:0]          device_address,
  input  logic [15:0]         data_word,
  input  logic                mdio_in,
  output mdioc45_pkg::item_t  item
);
  import mdioc45_pkg::*;

  logic [15:0] wr_hdr;
  logic [13:0] rd_hdr;

  // port and device fields in their header positions
  assign wr_hdr = {4'b0000, port_address, device_address, 2'b00};
  assign rd_hdr = {4'b0000, port_address, device_address};

  always_comb begin
    item.is_start = 1'b0;
    item.op       = OP_ADDR;
    item.frame    = '0;
    item.mdi      = mdio_in;
    case (command)
      CMD_ADDR: begin
        item.is_start = 1'b1;
        item.op       = OP_ADDR;
        item.frame    = {HDR_ADDR | wr_hdr, data_word};
      end
      CMD_WRITE: begin
        item.is_start = 1'b1;
        item.op       = OP_WRITE;
        item.frame    = {HDR_WRITE | wr_hdr, data_word};
      end
      CMD_READ: begin
        item.is_start = 1'b1;
        item.op       = OP_READ;
        item.frame    = {HDR_READ | rd_hdr, 18'b0};
      end
      CMD_READ_INC: begin
        item.is_start = 1'b1;
        item.op       = OP_READ_INC;
        item.frame    = {HDR_READ_INC | rd_hdr, 18'b0};
      end
      default: begin
        // tick and unused codes
        item.is_start = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/mdioc45_queue.sv @@
module mdioc45_queue #(
  parameter int unsigned DEPTH = mdioc45_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_stall,
  input  mdioc45_pkg::item_t  push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mdioc45_pkg::item_t  pop_item
);
  import mdioc45_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t              entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push, pop;

  assign push_stall = (count_r == CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/mdioc45_back.sv @@
module mdioc45_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          preamble_length,
  input  logic                item_valid,
  output logic                item_ready,
  input  mdioc45_pkg::item_t  item,
  output logic                res_valid,
  input  logic                res_stall,
  output mdioc45_pkg::res_t   res
);
  import mdioc45_pkg::*;

  localparam logic [2:0] PH_PREAMBLE = 3'd0;
  localparam logic [2:0] PH_SHIFT    = 3'd1;
  localparam logic [2:0] PH_TURN     = 3'd2;
  localparam logic [2:0] PH_SAMPLE   = 3'd3;
  localparam logic [2:0] PH_RELEASE  = 3'd4;

  localparam logic [7:0] LEN_WRITE  = 8'd32;
  localparam logic [7:0] LEN_READ   = 8'd14;
  localparam logic [7:0] LEN_SAMPLE = 8'd16;

  logic        active_r, active_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [31:0] out_shift_r, out_shift_nxt;
  logic [15:0] in_shift_r, in_shift_nxt;
  logic        res_valid_r, res_valid_nxt;
  res_t        res_r, res_nxt;
  logic [7:0]  count_dec;
  logic        take;
  logic        mdo, drv;

  assign item_ready = !res_valid_r || !res_stall;
  assign take       = item_valid && item_ready;
  assign count_dec  = count_r - 8'd1;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  always_comb begin
    active_nxt    = active_r;
    op_nxt        = op_r;
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    out_shift_nxt = out_shift_r;
    in_shift_nxt  = in_shift_r;
    res_nxt       = '0;
    mdo           = 1'b0;
    drv           = 1'b0;
    if (item.is_start) begin
      if (active_r) begin
        res_nxt.rejected = 1'b1;
      end else begin
        op_nxt        = item.op;
        out_shift_nxt = item.frame;
        in_shift_nxt  = '0;
        active_nxt    = 1'b1;
        mdo           = 1'b1;
        drv           = 1'b1;
        if (preamble_length == '0) begin
          phase_nxt = PH_SHIFT;
          count_nxt = item.op[1] ? LEN_READ : LEN_WRITE;
        end else begin
          phase_nxt = PH_PREAMBLE;
          count_nxt = preamble_length;
        end
      end
    end else if (active_r) begin
      res_nxt.mdc_pulse = 1'b1;
      case (phase_r)
        PH_PREAMBLE: begin
          mdo       = 1'b1;
          drv       = 1'b1;
          count_nxt = count_dec;
          if (count_dec == '0) begin
            phase_nxt = PH_SHIFT;
            count_nxt = op_r[1] ? LEN_READ : LEN_WRITE;
          end
        end
        PH_SHIFT: begin
          mdo           = out_shift_r[31];
          drv           = 1'b1;
          out_shift_nxt = {out_shift_r[30:0], 1'b0};
          count_nxt     = count_dec;
          if (count_dec == '0) begin
            phase_nxt = op_r[1] ? PH_TURN : PH_RELEASE;
          end
        end
        PH_TURN: begin
          phase_nxt    = PH_SAMPLE;
          count_nxt    = LEN_SAMPLE;
          in_shift_nxt = '0;
        end
        PH_SAMPLE: begin
          in_shift_nxt = {in_shift_r[14:0], item.mdi};
          count_nxt    = count_dec;
          if (count_dec == '0) begin
            phase_nxt = PH_RELEASE;
          end
        end
        default: begin
          // final release, also any unused phase code
          res_nxt.done = 1'b1;
          if (op_r[1]) begin
            res_nxt.read_data = in_shift_r;
          end
          active_nxt = 1'b0;
          phase_nxt  = PH_PREAMBLE;
          count_nxt  = '0;
        end
      endcase
    end
    res_nxt.mdio_out   = mdo & drv;
    res_nxt.mdio_drive = drv;
    res_nxt.busy       = active_nxt;
    res_valid_nxt      = take || (res_valid_r && res_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      op_r        <= OP_ADDR;
      phase_r     <= PH_PREAMBLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (take) begin
        active_r <= active_nxt;
        op_r     <= op_nxt;
        phase_r  <= phase_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_shift_r <= out_shift_nxt;
      in_shift_r  <= in_shift_nxt;
      res_r       <= res_nxt;
    end
  end

endmodule

@@ rtl/mdioc45_checker.sv @@
module mdioc45_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_mdc_pulse,
  input logic        out_mdio_out,
  input logic        out_mdio_drive,
  input logic        out_busy_res,
  input logic        out_done_res,
  input logic        out_start_rejected,
  input logic [15:0] out_read_data
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data)
      && $stable(out_done_res) && $stable(out_mdio_out))
    else $error("stalled result changed");

  // done ends a frame in an mdc period
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_mdc_pulse && !out_busy_res)
    else $error("done without period or still busy");

  // a rejected start leaves the frame running and drives nothing
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_rejected |->
      out_busy_res && !out_mdc_pulse && !out_mdio_drive && !out_done_res)
    else $error("bad rejected start result");

  // read data only appears with done
  a_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_data != 16'h0000) |-> out_done_res)
    else $error("read data without done");

  // the line is only driven high while the master drives it
  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mdio_out |-> out_mdio_drive && out_busy_res)
    else $error("mdio high while released or idle");

endmodule

bind mdio_clause45_master mdioc45_checker u_mdioc45_checker (.*);

@@ tb/mdio_clause45_master_tb.sv @@
`timescale 1ns / 1ps

module mdio_clause45_master_tb;
  import mdioc45_pkg::*;

  // cycles with no handshake on either side before the run is abandoned
  localparam int QuietLimit = 2000;
  // length of the long receiver hold-off used to fill the block
  localparam int HoldCycles = 60;
  // cycles left after the last result for the pipeline to settle
  localparam int SettleCycles = 4;
  // frame lengths in mdc periods for the driven and sampled parts of a frame
  localparam logic [7:0] LongHeaderBits  = 8'd32;
  localparam logic [7:0] ShortHeaderBits = 8'd14;
  localparam logic [7:0] ReadBits        = 8'd16;

  // where the frame engine stands between periods
  typedef enum logic [2:0] {
    PH_PREAMBLE,
    PH_SHIFT,
    PH_TURN,
    PH_SAMPLE,
    PH_RELEASE
  } phase_t;

  // how mdio_in is chosen for ticks of a frame
  typedef enum int {
    MDI_RANDOM,
    MDI_ONES,
    MDI_ZEROS
  } mdi_mode_t;

  // block ports; the inputs are driven to known levels from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = CMD_TICK;
  logic [4:0]  in_port_address = 5'd0;
  logic [4:0]  in_device_address = 5'd0;
  logic [15:0] in_data_word = 16'd0;
  logic        in_mdio_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_mdc_pulse;
  logic        out_mdio_out;
  logic        out_mdio_drive;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_start_rejected;
  logic [15:0] out_read_data;

  // shadow of the frame engine, advanced once per accepted item
  logic [7:0]  preamble_len = PreambleReset;
  logic        fr_active = 1'b0;
  logic [1:0]  fr_op = OP_ADDR;
  phase_t      fr_phase = PH_PREAMBLE;
  logic [7:0]  fr_count = 8'd0;
  logic [31:0] fr_shift = 32'd0;
  logic [15:0] rd_shift = 16'd0;

  // pin levels expected for each accepted item, oldest first
  res_t pin_expect[$];

  int  errors = 0;
  int  items_sent = 0;
  bit  idle_on = 1'b1;
  int  hold_token = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  mdio_clause45_master dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_port_address   (in_port_address),
    .in_device_address (in_device_address),
    .in_data_word      (in_data_word),
    .in_mdio_in        (in_mdio_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mdc_pulse     (out_mdc_pulse),
    .out_mdio_out      (out_mdio_out),
    .out_mdio_drive    (out_mdio_drive),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_start_rejected(out_start_rejected),
    .out_read_data     (out_read_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // header bits follow the preamble, or the start itself when it is empty
  function automatic void enter_header();
    fr_phase = PH_SHIFT;
    fr_count = (fr_op == OP_ADDR || fr_op == OP_WRITE) ? LongHeaderBits : ShortHeaderBits;
  endfunction

  // pin levels for one item, moving the shadow engine on by one step
  function automatic res_t mdio_period(logic [2:0] cmd, logic [4:0] port, logic [4:0] dev,
                                       logic [15:0] word, logic mdi);
    res_t r;
    r = '0;
    if (cmd == CMD_ADDR || cmd == CMD_WRITE || cmd == CMD_READ || cmd == CMD_READ_INC) begin
      if (fr_active) begin
        // start while a frame runs: flagged, nothing else moves
        r.rejected = 1'b1;
      end else begin
        case (cmd)
          CMD_ADDR:  fr_op = OP_ADDR;
          CMD_WRITE: fr_op = OP_WRITE;
          CMD_READ:  fr_op = OP_READ;
          default:   fr_op = OP_READ_INC;
        endcase
        case (fr_op)
          OP_ADDR:  fr_shift = {HDR_ADDR | ({11'd0, port} << 7) | ({11'd0, dev} << 2), word};
          OP_WRITE: fr_shift = {HDR_WRITE | ({11'd0, port} << 7) | ({11'd0, dev} << 2), word};
          OP_READ:  fr_shift = {HDR_READ | ({9'd0, port} << 5) | {9'd0, dev}, 18'd0};
          default:  fr_shift = {HDR_READ_INC | ({9'd0, port} << 5) | {9'd0, dev}, 18'd0};
        endcase
        rd_shift = 16'd0;
        fr_active = 1'b1;
        if (preamble_len == 8'd0) begin
          enter_header();
        end else begin
          fr_phase = PH_PREAMBLE;
          fr_count = preamble_len;
        end
        r.mdio_out = 1'b1;
        r.mdio_drive = 1'b1;
      end
    end else if (fr_active) begin
      // a tick (or an unused code) while a frame runs is one mdc period
      r.mdc_pulse = 1'b1;
      case (fr_phase)
        PH_PREAMBLE: begin
          r.mdio_out = 1'b1;
          r.mdio_drive = 1'b1;
          fr_count = fr_count - 8'd1;
          if (fr_count == 8'd0) enter_header();
        end
        PH_SHIFT: begin
          r.mdio_out = fr_shift[31];
          r.mdio_drive = 1'b1;
          fr_shift = fr_shift << 1;
          fr_count = fr_count - 8'd1;
          if (fr_count == 8'd0)
            fr_phase = (fr_op == OP_ADDR || fr_op == OP_WRITE) ? PH_RELEASE : PH_TURN;
        end
        PH_TURN: begin
          fr_phase = PH_SAMPLE;
          fr_count = ReadBits;
          rd_shift = 16'd0;
        end
        PH_SAMPLE: begin
          rd_shift = {rd_shift[14:0], mdi};
          fr_count = fr_count - 8'd1;
          if (fr_count == 8'd0) fr_phase = PH_RELEASE;
        end
        default: begin
          r.done = 1'b1;
          if (fr_op == OP_READ || fr_op == OP_READ_INC) r.read_data = rd_shift;
          fr_active = 1'b0;
          fr_phase = PH_PREAMBLE;
          fr_count = 8'd0;
        end
      endcase
    end
    r.busy = fr_active;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_pins();
    res_t exp_r;
    if (pin_expect.size() == 0) begin
      $display("%0t: result item with nothing expected, expected none, got busy=%b done=%b",
               $time, out_busy_res, out_done_res);
      errors++;
    end else begin
      exp_r = pin_expect.pop_front();
      compare_field("mdc_pulse", 16'(exp_r.mdc_pulse), 16'(out_mdc_pulse));
      compare_field("mdio_out", 16'(exp_r.mdio_out), 16'(out_mdio_out));
      compare_field("mdio_drive", 16'(exp_r.mdio_drive), 16'(out_mdio_drive));
      compare_field("busy_res", 16'(exp_r.busy), 16'(out_busy_res));
      compare_field("done_res", 16'(exp_r.done), 16'(out_done_res));
      compare_field("start_rejected", 16'(exp_r.rejected), 16'(out_start_rejected));
      compare_field("read_data", exp_r.read_data, out_read_data);
    end
  endtask

  // result side: checks each accepted item, then draws its own stall;
  // a long hold-off is ordered by bumping hold_token
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_pins();
        stall_left = idle_on ? $urandom_range(8) : 0;
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long without any handshake means the block has hung
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
        $display("[mdio_clause45_master] ERROR");
        $finish;
      end
    end
  end

  // offer one item, after a random gap when idle_on is set, and wait until it is taken
  task automatic send_item(logic [2:0] cmd, logic [4:0] port, logic [4:0] dev,
                           logic [15:0] word, logic mdi);
    int gap;
    gap = idle_on ? $urandom_range(8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_port_address <= port;
    in_device_address <= dev;
    in_data_word <= word;
    in_mdio_in <= mdi;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pin_expect.push_back(mdio_period(cmd, port, dev, word, mdi));
    items_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pin_expect.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_preamble(logic [7:0] len);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    preamble_len = len;
  endtask

  // ticks until the frame ends; some slots carry a stray start or unused code
  task automatic tick_to_idle(int noise_pct, mdi_mode_t mode);
    logic mdi;
    while (fr_active) begin
      case (mode)
        MDI_ONES:  mdi = 1'b1;
        MDI_ZEROS: mdi = 1'b0;
        default:   mdi = 1'($urandom);
      endcase
      if ($urandom_range(99) < noise_pct)
        send_item(3'($urandom_range(7, 1)), 5'($urandom), 5'($urandom), 16'($urandom), mdi);
      else
        send_item(CMD_TICK, 5'($urandom), 5'($urandom), 16'($urandom), mdi);
    end
  endtask

  task automatic run_frame(logic [2:0] cmd, logic [4:0] port, logic [4:0] dev,
                           logic [15:0] word, int noise_pct, mdi_mode_t mode);
    send_item(cmd, port, dev, word, 1'($urandom));
    tick_to_idle(noise_pct, mode);
  endtask

  function automatic logic [2:0] any_start();
    return 3'($urandom_range(CMD_READ_INC, CMD_ADDR));
  endfunction

  // ticks and unused codes while idle do nothing at all
  task automatic test_idle_ticks();
    send_item(CMD_TICK, 5'd31, 5'd31, 16'hffff, 1'b1);
    send_item(CMD_TICK, 5'd0, 5'd0, 16'h0000, 1'b0);
    send_item(3'd5, 5'd31, 5'd0, 16'hffff, 1'b1);
    send_item(3'd6, 5'd0, 5'd31, 16'h0000, 1'b0);
    send_item(3'd7, 5'd31, 5'd31, 16'ha5a5, 1'b1);
  endtask

  // one address frame with the preamble length left at its reset value
  task automatic test_reset_preamble();
    run_frame(CMD_ADDR, 5'd31, 5'd31, 16'hffff, 0, MDI_RANDOM);
  endtask

  // every operation with the fields at their extremes, no preamble
  task automatic test_frame_extremes();
    set_preamble(8'd0);
    run_frame(CMD_WRITE, 5'd0, 5'd0, 16'h0000, 0, MDI_RANDOM);
    run_frame(CMD_ADDR, 5'd0, 5'd31, 16'h8001, 0, MDI_RANDOM);
    run_frame(CMD_WRITE, 5'd31, 5'd31, 16'hffff, 0, MDI_RANDOM);
    run_frame(CMD_READ, 5'd31, 5'd31, 16'hffff, 0, MDI_ONES);
    run_frame(CMD_READ_INC, 5'd0, 5'd0, 16'h0000, 0, MDI_ZEROS);
    run_frame(CMD_READ, 5'd21, 5'd10, 16'h1234, 0, MDI_RANDOM);
  endtask

  // starts of each kind and unused codes thrown in while a frame runs
  task automatic test_rejected_starts();
    set_preamble(8'd2);
    send_item(CMD_READ, 5'd5, 5'd3, 16'h0, 1'b0);
    send_item(CMD_ADDR, 5'd1, 5'd1, 16'h1111, 1'b0);
    send_item(CMD_WRITE, 5'd2, 5'd2, 16'h2222, 1'b1);
    send_item(CMD_READ, 5'd3, 5'd3, 16'h3333, 1'b0);
    send_item(CMD_READ_INC, 5'd4, 5'd4, 16'h4444, 1'b1);
    send_item(3'd5, 5'd0, 5'd0, 16'h0, 1'b1);
    send_item(3'd6, 5'd0, 5'd0, 16'h0, 1'b0);
    send_item(3'd7, 5'd0, 5'd0, 16'h0, 1'b1);
    tick_to_idle(30, MDI_RANDOM);
    run_frame(CMD_WRITE, 5'($urandom), 5'($urandom), 16'($urandom), 30, MDI_RANDOM);
  endtask

  // preamble lengths from one to the longest, then back to the reset value
  task automatic test_preamble_lengths();
    set_preamble(8'd1);
    run_frame(CMD_READ_INC, 5'($urandom), 5'($urandom), 16'($urandom), 0, MDI_RANDOM);
    set_preamble(8'd255);
    run_frame(CMD_ADDR, 5'($urandom), 5'($urandom), 16'($urandom), 5, MDI_RANDOM);
    set_preamble(8'($urandom_range(15)));
    run_frame(any_start(), 5'($urandom), 5'($urandom), 16'($urandom), 5, MDI_RANDOM);
    set_preamble(PreambleReset);
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    set_preamble(8'd4);
    idle_on = 1'b0;
    hold_token++;
    run_frame(CMD_READ, 5'($urandom), 5'($urandom), 16'($urandom), 10, MDI_RANDOM);
    run_frame(CMD_WRITE, 5'($urandom), 5'($urandom), 16'($urandom), 0, MDI_RANDOM);
    idle_on = 1'b1;
  endtask

  // sender stops mid frame until every result is back, then carries on
  task automatic test_sender_pause();
    send_item(CMD_READ_INC, 5'($urandom), 5'($urandom), 16'($urandom), 1'b0);
    repeat (10) send_item(CMD_TICK, 5'd0, 5'd0, 16'd0, 1'($urandom));
    wait_drained();
    tick_to_idle(0, MDI_RANDOM);
  endtask

  // mostly whole frames with random content; some noise bursts and retuning
  task automatic test_random_traffic();
    int target;
    int pick;
    target = items_sent + 100;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      idle_on = ($urandom_range(3) != 0);
      if (pick < 8) begin
        if ($urandom_range(9) == 0) set_preamble(8'($urandom));
        else set_preamble(8'($urandom_range(15)));
      end else if (pick < 85) begin
        run_frame(any_start(), 5'($urandom), 5'($urandom), 16'($urandom), 10, MDI_RANDOM);
      end else begin
        repeat ($urandom_range(4, 1))
          send_item(3'($urandom), 5'($urandom), 5'($urandom), 16'($urandom), 1'($urandom));
        tick_to_idle(10, MDI_RANDOM);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    // reset held low from time zero, released at a rising edge
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_reset_preamble();
    test_frame_extremes();
    test_rejected_starts();
    test_preamble_lengths();
    test_backpressure();
    test_sender_pause();
    test_random_traffic();

    wait_drained();
    if (errors == 0)
      $display("[mdio_clause45_master] OK");
    else
      $display("[mdio_clause45_master] ERROR");
    $finish;
  end

endmodule
